@@ sv/hs_pkg.sv @@
// ----------------------------------------------------------------------------
// hs_pkg: shared types and constants for the hillshade stencil
// Holds field widths, status and register codes, the configuration bundle,
// the queued work item and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hs_pkg;

  localparam int MAX_COLS_DEF     = 2048;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam int ELEV_W     = 24;
  localparam int CELL_W     = 25;
  localparam int GRAD_W     = 27;
  localparam int COL_W      = 11;
  localparam int SLOPE_W    = 14;
  localparam int ASPECT_W   = 16;
  localparam int SHADE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [35:0] INV_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [18:0] PI_Q13       = 19'sd25736;
  localparam logic signed [18:0] HALF_PI_Q13  = 19'sd12868;
  localparam logic signed [18:0] TWO_PI_Q13   = 19'sd51472;

  localparam logic [11:0] ROW_WIDTH_RST   = 12'd2048;
  localparam logic [15:0] CELL_SIZE_RST   = 16'd1;
  localparam logic [15:0] Z_FACTOR_RST    = 16'd256;
  localparam logic [14:0] COS_ZENITH_RST  = 15'd23170;
  localparam logic [14:0] SIN_ZENITH_RST  = 15'd23170;
  localparam logic [15:0] SUN_AZIMUTH_RST = 16'd19302;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH   = 3'd0,
    REG_CELL_SIZE   = 3'd1,
    REG_Z_FACTOR    = 3'd2,
    REG_COS_ZENITH  = 3'd3,
    REG_SIN_ZENITH  = 3'd4,
    REG_SUN_AZIMUTH = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_COMPUTED        = 2'd0,
    ST_CENTER_NODATA   = 2'd1,
    ST_NEIGHBOR_NODATA = 2'd2
  } status_t;

  typedef struct packed {
    logic [11:0] row_width;
    logic [15:0] cell_size;
    logic [15:0] z_factor;
    logic [14:0] cos_zenith;
    logic [14:0] sin_zenith;
    logic [15:0] sun_azimuth;
  } cfg_t;

  typedef struct packed {
    status_t                  status;
    logic [COL_W-1:0]         center_column;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } work_t;

  // Arctangent of 2^-i in Q2.30, truncated.
  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sh3243F6A8;
      5'd1:  v = 32'sh1DAC6705;
      5'd2:  v = 32'sh0FADBAFC;
      5'd3:  v = 32'sh07F56EA6;
      5'd4:  v = 32'sh03FEAB76;
      5'd5:  v = 32'sh01FFD55B;
      5'd6:  v = 32'sh00FFFAAA;
      5'd7:  v = 32'sh007FFF55;
      5'd8:  v = 32'sh003FFFEA;
      5'd9:  v = 32'sh001FFFFD;
      5'd10: v = 32'sh000FFFFF;
      5'd11: v = 32'sh0007FFFF;
      5'd12: v = 32'sh0003FFFF;
      5'd13: v = 32'sh0001FFFF;
      5'd14: v = 32'sh0000FFFF;
      5'd15: v = 32'sh00007FFF;
      5'd16: v = 32'sh00003FFF;
      5'd17: v = 32'sh00001FFF;
      5'd18: v = 32'sh00000FFF;
      5'd19: v = 32'sh000007FF;
      5'd20: v = 32'sh000003FF;
      5'd21: v = 32'sh000001FF;
      5'd22: v = 32'sh000000FF;
      5'd23: v = 32'sh0000007F;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/hs_ifs.sv @@
// ----------------------------------------------------------------------------
// hs_ifs: channel interfaces of the hillshade stencil
// Sample input, result output and configuration write channels, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface hs_sample_if;
  logic        valid;
  logic        ready;
  logic [23:0] elevation;
  logic        no_data;
  logic        frame_start;
  modport source (output valid, elevation, no_data, frame_start, input ready);
  modport sink (input valid, elevation, no_data, frame_start, output ready);
endinterface

interface hs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] center_column;
  logic [13:0] slope_angle;
  logic [15:0] aspect_angle;
  logic [15:0] shade;
  modport source (output valid, status, center_column, slope_angle, aspect_angle, shade,
                  input ready);
  modport sink (input valid, status, center_column, slope_angle, aspect_angle, shade,
                output ready);
endinterface

interface hs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/hs_ram.sv @@
// ----------------------------------------------------------------------------
// hs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hs_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/hs_fifo.sv @@
// ----------------------------------------------------------------------------
// hs_fifo: work queue between the window front end and the math back end
// Small register queue of classified window items.
// ----------------------------------------------------------------------------
module hs_fifo #(
  parameter int DEPTH = hs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  hs_pkg::work_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hs_pkg::work_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hs_pkg::work_t    slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PW + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

endmodule

@@ sv/hs_front.sv @@
// ----------------------------------------------------------------------------
// hs_front: sample intake, line stores and 3x3 window
// Takes one sample, reads both line stores at its column, shifts the window
// and queues a classified item with Horn gradients for each interior center.
// ----------------------------------------------------------------------------
module hs_front #(
  parameter int MAX_COLS = hs_pkg::MAX_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  hs_sample_if.sink        samples,
  input  logic [11:0]      row_width,
  output logic             push_valid,
  input  logic             push_ready,
  output hs_pkg::work_t    push_data
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WW = (AW + 1 > 12) ? AW + 1 : 12;

  typedef enum logic [1:0] {S_TAKE, S_SHIFT, S_PUSH} state_t;

  state_t              state;
  logic [AW-1:0]       column_count;
  logic [AW-1:0]       col;
  logic [1:0]          row_count;
  logic [24:0]         nw;
  logic                emit;
  logic [24:0]         win [9];

  logic                take;
  logic [AW-1:0]       col_in;
  logic [1:0]          row_in;
  logic [WW-1:0]       width_req;
  logic [WW-1:0]       width_eff;
  logic [WW-1:0]       col_plus;
  logic [WW-1:0]       center_w;
  logic [24:0]         upper_rd;
  logic [24:0]         lower_rd;
  logic                ram_we;
  logic signed [26:0]  e [9];
  logic signed [26:0]  gx;
  logic signed [26:0]  gy;
  logic                neigh_nd;

  assign take          = samples.valid && samples.ready;
  assign samples.ready = (state == S_TAKE) && push_ready;
  assign col_in        = samples.frame_start ? '0 : column_count;
  assign row_in        = samples.frame_start ? 2'd0 : row_count;
  assign width_req     = WW'(row_width);
  assign col_plus      = WW'(col_in) + WW'(1);
  assign ram_we        = (state == S_SHIFT);

  always_comb begin
    if (width_req < WW'(3)) begin
      width_eff = WW'(3);
    end else if (width_req > WW'(MAX_COLS)) begin
      width_eff = WW'(MAX_COLS);
    end else begin
      width_eff = width_req;
    end
  end

  hs_ram #(.WIDTH(hs_pkg::CELL_W), .DEPTH(MAX_COLS)) u_upper (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (col),
    .wr_data (lower_rd),
    .rd_addr (col_in),
    .rd_data (upper_rd)
  );

  hs_ram #(.WIDTH(hs_pkg::CELL_W), .DEPTH(MAX_COLS)) u_lower (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (col),
    .wr_data (nw),
    .rd_addr (col_in),
    .rd_data (lower_rd)
  );

  always_comb begin
    neigh_nd = 1'b0;
    for (int k = 0; k < 9; k++) begin
      e[k] = 27'(signed'(win[k][23:0]));
      if (k != 4 && win[k][24]) begin
        neigh_nd = 1'b1;
      end
    end
    gx = (e[2] + (e[5] <<< 1) + e[8]) - (e[0] + (e[3] <<< 1) + e[6]);
    gy = (e[0] + (e[1] <<< 1) + e[2]) - (e[6] + (e[7] <<< 1) + e[8]);
  end

  assign center_w   = WW'(col) - WW'(1);
  assign push_valid = (state == S_PUSH);

  always_comb begin
    push_data.center_column = center_w[10:0];
    push_data.gx            = gx;
    push_data.gy            = gy;
    if (win[4][24]) begin
      push_data.status = hs_pkg::ST_CENTER_NODATA;
    end else if (neigh_nd) begin
      push_data.status = hs_pkg::ST_NEIGHBOR_NODATA;
    end else begin
      push_data.status = hs_pkg::ST_COMPUTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_TAKE;
      column_count <= '0;
      row_count    <= 2'd0;
      emit         <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      unique case (state)
        S_TAKE: begin
          if (take) begin
            col   <= col_in;
            nw    <= {samples.no_data, samples.elevation};
            emit  <= (row_in >= 2'd2) && (col_in >= AW'(2));
            if (col_plus >= width_eff) begin
              column_count <= '0;
              row_count    <= (row_in < 2'd2) ? row_in + 2'd1 : row_in;
            end else begin
              column_count <= col_plus[AW-1:0];
              row_count    <= row_in;
            end
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          for (int r = 0; r < 3; r++) begin
            win[r*3]   <= win[r*3+1];
            win[r*3+1] <= win[r*3+2];
          end
          win[2] <= upper_rd;
          win[5] <= lower_rd;
          win[8] <= nw;
          state  <= emit ? S_PUSH : S_TAKE;
        end
        S_PUSH: begin
          state <= S_TAKE;
        end
        default: state <= S_TAKE;
      endcase
    end
  end

  // The queue had room when the sample was taken and nothing else pushes.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("window item pushed into a full queue");

  a_single_intake: assert property (@(posedge clk) disable iff (rst)
    take |=> !samples.ready)
    else $error("second sample taken while the window is updating");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (col >= AW'(2)))
    else $error("result queued for a border center");

endmodule

@@ sv/hs_back.sv @@
// ----------------------------------------------------------------------------
// hs_back: slope, aspect and hillshade engine
// Runs computed items through one shared CORDIC unit and one shared multiplier;
// no-data items skip both. Every result is held in an output register.
// ----------------------------------------------------------------------------
module hs_back #(
  parameter int CORDIC_STEPS = hs_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  hs_pkg::work_t  pop_data,
  input  hs_pkg::cfg_t   cfg,
  hs_result_if.source    results
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    B_IDLE, B_VEC_A, B_MHI, B_MLO, B_ZL, B_ZH, B_VEC_S, B_ROT_S, B_ROT_D,
    B_P1, B_P2, B_P3, B_P4, B_DONE
  } state_t;

  state_t              state;
  hs_pkg::work_t       item;
  logic signed [63:0]  x;
  logic signed [63:0]  y;
  logic signed [35:0]  acc;
  logic [IW-1:0]       step;
  logic signed [31:0]  cs;
  logic signed [31:0]  ss;
  logic signed [63:0]  tmp;
  logic [1:0]          p_status;
  logic [10:0]         p_col;
  logic [13:0]         p_slope;
  logic signed [15:0]  p_aspect;
  logic [15:0]         p_shade;
  logic                res_valid;
  logic [1:0]          res_status;
  logic [10:0]         res_col;
  logic [13:0]         res_slope;
  logic [15:0]         res_aspect;
  logic [15:0]         res_shade;

  logic                is_vec;
  logic                up;
  logic signed [63:0]  sh_x;
  logic signed [63:0]  sh_y;
  logic signed [35:0]  t_atan;
  logic signed [63:0]  x_it;
  logic signed [63:0]  y_it;
  logic signed [35:0]  a_it;
  logic                last;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  product;
  logic signed [63:0]  prod64;
  logic signed [63:0]  vx0;
  logic signed [63:0]  vy0;
  logic signed [63:0]  gx_s;
  logic signed [63:0]  gy_s;
  logic signed [35:0]  va0;
  logic signed [18:0]  slope_next;
  logic signed [18:0]  aspect_cordic;
  logic signed [15:0]  aspect_next;
  logic signed [17:0]  az;
  logic signed [17:0]  d_raw;
  logic signed [17:0]  d_wrap;
  logic signed [35:0]  rot_a;
  logic signed [63:0]  rx0;
  logic signed [63:0]  ry0;
  logic signed [35:0]  ra0;
  logic [15:0]         cell_eff;
  logic signed [63:0]  shade_v;
  logic [15:0]         shade_next;

  function automatic logic signed [18:0] to_q13(input logic signed [35:0] a,
                                                input logic signed [18:0] lo,
                                                input logic signed [18:0] hi);
    logic signed [35:0] r;
    r = (a + 36'sd65536) >>> 17;
    if (r < 36'(lo)) begin
      return lo;
    end else if (r > 36'(hi)) begin
      return hi;
    end
    return r[18:0];
  endfunction

  // Shared CORDIC step; vectoring drives y to zero, rotation drives the angle.
  assign is_vec = (state == B_VEC_A) || (state == B_VEC_S);
  assign sh_x   = x >>> step;
  assign sh_y   = y >>> step;
  assign t_atan = 36'(hs_pkg::atan_q30(5'(step)));
  assign up     = is_vec ? (y > 64'sd0) : (acc < 36'sd0);
  assign x_it   = up ? x + sh_y : x - sh_y;
  assign y_it   = up ? y - sh_x : y + sh_x;
  assign a_it   = up ? acc + t_atan : acc - t_atan;
  assign last   = (step == LAST);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_MHI: begin
        mul_a = 33'(x >>> 15);
        mul_b = 33'(hs_pkg::INV_GAIN_Q30);
      end
      B_MLO: begin
        mul_a = 33'({1'b0, x[14:0]});
        mul_b = 33'(hs_pkg::INV_GAIN_Q30);
      end
      B_ZL: begin
        mul_a = 33'({1'b0, y[21:0]});
        mul_b = 33'({1'b0, cfg.z_factor});
      end
      B_ZH: begin
        mul_a = 33'(y >>> 22);
        mul_b = 33'({1'b0, cfg.z_factor});
      end
      B_P1: begin
        mul_a = 33'({1'b0, cfg.sin_zenith});
        mul_b = 33'(ss);
      end
      B_P2: begin
        mul_a = 33'(tmp);
        mul_b = 33'(x);
      end
      B_P3: begin
        mul_a = 33'({1'b0, cfg.cos_zenith});
        mul_b = 33'(cs);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign prod64  = 64'(product);

  // Aspect vectoring start, rotated into the right half plane when gx < 0.
  always_comb begin
    gx_s = 64'(signed'(pop_data.gx)) <<< 16;
    gy_s = 64'(signed'(pop_data.gy)) <<< 16;
    if (gx_s < 64'sd0) begin
      if (gy_s >= 64'sd0) begin
        vx0 = gy_s;
        vy0 = -gx_s;
        va0 = hs_pkg::HALF_PI_Q30;
      end else begin
        vx0 = -gy_s;
        vy0 = gx_s;
        va0 = -hs_pkg::HALF_PI_Q30;
      end
    end else begin
      vx0 = gx_s;
      vy0 = gy_s;
      va0 = '0;
    end
  end

  assign slope_next    = to_q13(a_it, 19'sd0, hs_pkg::HALF_PI_Q13);
  assign aspect_cordic = to_q13(a_it, -hs_pkg::PI_Q13, hs_pkg::PI_Q13);

  always_comb begin
    if (item.gx == '0 && item.gy == '0) begin
      aspect_next = '0;
    end else if (item.gx == '0) begin
      aspect_next = (item.gy > 27'sd0) ? 16'(hs_pkg::HALF_PI_Q13)
                                       : 16'(-hs_pkg::HALF_PI_Q13);
    end else if (item.gy == '0) begin
      aspect_next = (item.gx > 27'sd0) ? 16'sd0 : 16'(hs_pkg::PI_Q13);
    end else begin
      aspect_next = aspect_cordic[15:0];
    end
  end

  // Sun-relative azimuth, aspect first wrapped into 0..2pi.
  always_comb begin
    az     = (p_aspect < 16'sd0) ? 18'(p_aspect) + 18'(hs_pkg::TWO_PI_Q13)
                                 : 18'(p_aspect);
    d_raw  = signed'({2'b00, cfg.sun_azimuth}) - az;
    if (d_raw > 18'(hs_pkg::PI_Q13)) begin
      d_wrap = d_raw - 18'(hs_pkg::TWO_PI_Q13);
    end else if (d_raw < 18'(-hs_pkg::PI_Q13)) begin
      d_wrap = d_raw + 18'(hs_pkg::TWO_PI_Q13);
    end else begin
      d_wrap = d_raw;
    end
  end

  // Rotation start with a quarter-turn pre-rotation beyond +-pi/2.
  always_comb begin
    rot_a = (state == B_VEC_S) ? (36'(slope_next) <<< 17) : (36'(d_wrap) <<< 17);
    if (rot_a > hs_pkg::HALF_PI_Q30) begin
      rx0 = '0;
      ry0 = 64'(hs_pkg::INV_GAIN_Q30);
      ra0 = rot_a - hs_pkg::HALF_PI_Q30;
    end else if (rot_a < -hs_pkg::HALF_PI_Q30) begin
      rx0 = '0;
      ry0 = -64'(hs_pkg::INV_GAIN_Q30);
      ra0 = rot_a + hs_pkg::HALF_PI_Q30;
    end else begin
      rx0 = 64'(hs_pkg::INV_GAIN_Q30);
      ry0 = '0;
      ra0 = rot_a;
    end
  end

  assign cell_eff = (cfg.cell_size == '0) ? 16'd1 : cfg.cell_size;

  always_comb begin
    shade_v = (tmp + 64'sd268435456) >>> 29;
    if (shade_v < 64'sd0) begin
      shade_next = '0;
    end else if (shade_v > 64'sd65535) begin
      shade_next = 16'hFFFF;
    end else begin
      shade_next = shade_v[15:0];
    end
  end

  assign pop_ready             = (state == B_IDLE);
  assign results.valid         = res_valid;
  assign results.status        = res_status;
  assign results.center_column = res_col;
  assign results.slope_angle   = res_slope;
  assign results.aspect_angle  = res_aspect;
  assign results.shade         = res_shade;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      // In B_DONE a transfer of the held result always reloads the register.
      if (results.valid && results.ready && state != B_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            item     <= pop_data;
            p_status <= 2'(pop_data.status);
            p_col    <= pop_data.center_column;
            p_slope  <= '0;
            p_aspect <= '0;
            p_shade  <= '0;
            x        <= vx0;
            y        <= vy0;
            acc      <= va0;
            step     <= '0;
            state    <= (pop_data.status == hs_pkg::ST_COMPUTED) ? B_VEC_A : B_DONE;
          end
        end
        B_VEC_A: begin
          x    <= x_it;
          y    <= y_it;
          acc  <= a_it;
          step <= step + IW'(1);
          if (last) begin
            p_aspect <= aspect_next;
            state    <= B_MHI;
          end
        end
        B_MHI: begin
          y     <= prod64;
          state <= B_MLO;
        end
        B_MLO: begin
          y     <= (y + (prod64 >>> 15)) >>> 15;
          state <= B_ZL;
        end
        B_ZL: begin
          x     <= prod64;
          state <= B_ZH;
        end
        B_ZH: begin
          y     <= x + (prod64 <<< 22);
          x     <= 64'({cell_eff}) <<< 27;
          acc   <= '0;
          step  <= '0;
          state <= B_VEC_S;
        end
        B_VEC_S: begin
          step <= step + IW'(1);
          if (last) begin
            p_slope <= slope_next[13:0];
            x       <= rx0;
            y       <= ry0;
            acc     <= ra0;
            step    <= '0;
            state   <= B_ROT_S;
          end else begin
            x   <= x_it;
            y   <= y_it;
            acc <= a_it;
          end
        end
        B_ROT_S: begin
          step <= step + IW'(1);
          if (last) begin
            cs    <= 32'(x_it);
            ss    <= 32'(y_it);
            x     <= rx0;
            y     <= ry0;
            acc   <= ra0;
            step  <= '0;
            state <= B_ROT_D;
          end else begin
            x   <= x_it;
            y   <= y_it;
            acc <= a_it;
          end
        end
        B_ROT_D: begin
          x    <= x_it;
          y    <= y_it;
          acc  <= a_it;
          step <= step + IW'(1);
          if (last) begin
            state <= B_P1;
          end
        end
        B_P1: begin
          tmp   <= prod64 >>> 15;
          state <= B_P2;
        end
        B_P2: begin
          tmp   <= prod64 >>> 15;
          state <= B_P3;
        end
        B_P3: begin
          tmp   <= tmp + prod64;
          state <= B_P4;
        end
        B_P4: begin
          p_shade <= shade_next;
          state   <= B_DONE;
        end
        B_DONE: begin
          if (!res_valid || results.ready) begin
            res_valid  <= 1'b1;
            res_status <= p_status;
            res_col    <= p_col;
            res_slope  <= p_slope;
            res_aspect <= p_aspect;
            res_shade  <= p_shade;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != 2'(hs_pkg::ST_COMPUTED)) |->
      (res_slope == '0 && res_aspect == '0 && res_shade == '0))
    else $error("no-data result carries nonzero angles or shade");

  a_slope_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_slope <= 14'd12868))
    else $error("slope beyond a quarter turn");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (state != B_IDLE))
    else $error("queued item taken but engine stayed idle");

endmodule

@@ sv/hillshade_3x3_stencil.sv @@
// ----------------------------------------------------------------------------
// hillshade_3x3_stencil: Horn slope, aspect and hillshade over a raster stream
// Windowing front end, work queue and CORDIC back end with configuration.
// ----------------------------------------------------------------------------
// Front end: a sample is accepted with the line store read, then the window is
// updated and, for an interior center, the item is queued; no new sample is
// taken until that is done, nor while the queue is full. A computed center runs
// through the shared CORDIC unit and multiplier; a no-data center goes straight
// to the output register. The back end sets the sustained rate.
// Reset clears counters, window, queue and result valid and loads default
// configuration; the line stores are not cleared and hold no data until written.
module hillshade_3x3_stencil #(
  parameter int MAX_COLS     = hs_pkg::MAX_COLS_DEF,
  parameter int CORDIC_STEPS = hs_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  hs_sample_if.sink    samples,
  hs_result_if.source  results,
  hs_cfg_if.sink       cfg
);

  // Configuration registers: write only while the block is idle; not enforced.
  hs_pkg::cfg_t  cfg_regs;

  // Queue between the window front end and the math back end.
  logic          push_valid;
  logic          push_ready;
  hs_pkg::work_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  hs_pkg::work_t pop_data;

  // Every configuration transfer completes at once; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.row_width   <= hs_pkg::ROW_WIDTH_RST;
      cfg_regs.cell_size   <= hs_pkg::CELL_SIZE_RST;
      cfg_regs.z_factor    <= hs_pkg::Z_FACTOR_RST;
      cfg_regs.cos_zenith  <= hs_pkg::COS_ZENITH_RST;
      cfg_regs.sin_zenith  <= hs_pkg::SIN_ZENITH_RST;
      cfg_regs.sun_azimuth <= hs_pkg::SUN_AZIMUTH_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        hs_pkg::REG_ROW_WIDTH:   cfg_regs.row_width   <= cfg.data[11:0];
        hs_pkg::REG_CELL_SIZE:   cfg_regs.cell_size   <= cfg.data;
        hs_pkg::REG_Z_FACTOR:    cfg_regs.z_factor    <= cfg.data;
        hs_pkg::REG_COS_ZENITH:  cfg_regs.cos_zenith  <= cfg.data[14:0];
        hs_pkg::REG_SIN_ZENITH:  cfg_regs.sin_zenith  <= cfg.data[14:0];
        hs_pkg::REG_SUN_AZIMUTH: cfg_regs.sun_azimuth <= cfg.data;
        default: ;
      endcase
    end
  end

  // The front end owns the line stores and the window. It classifies each
  // interior center and computes its Horn gradients before queueing it.
  hs_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .row_width  (cfg_regs.row_width),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the front end keep taking samples while the back end
  // grinds through the trigonometry of an earlier center.
  hs_fifo #(.DEPTH(hs_pkg::QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end computes aspect, slope and shade and holds the result in an
  // output register, so it can start the next item while a result waits.
  hs_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg       (cfg_regs),
    .results   (results)
  );

endmodule
